>>> rtl/core/ogsp_pkg.sv
// Shared constants, request codes and a clamp helper for the occupancy grid painter.
package ogsp_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
    localparam int DIM_W       = 9;
    localparam int CS_W        = 23;
    localparam int POS_W       = 24;
    localparam int QUO_W       = 26;

    localparam logic [2:0] REQ_SET_CELL  = 3'd0;
    localparam logic [2:0] REQ_SET_POINT = 3'd1;
    localparam logic [2:0] REQ_FILL_RECT = 3'd2;
    localparam logic [2:0] REQ_FILL_CIRC = 3'd3;
    localparam logic [2:0] REQ_READ_CELL = 3'd4;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CELL_SIZE   = 2'd2;

    // Clamp a signed cell index to [0, dim - 1]; the result is used only when dim is nonzero.
    function automatic logic [COL_BITS-1:0] clamp_idx(input logic signed [QUO_W-1:0] q,
                                                      input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] hi;
        hi = dim - 9'd1;
        if (q < 0)
            clamp_idx = '0;
        else if (q > $signed({{(QUO_W-DIM_W){1'b0}}, hi}))
            clamp_idx = hi[COL_BITS-1:0];
        else
            clamp_idx = q[COL_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/ogsp_if.sv
// Handshake channels: request, response and configuration write.
interface ogsp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] corner_x;
    logic signed [23:0] corner_y;
    logic [22:0]        radius;
    logic               walkable;
    modport source (output valid, req_type, pos_x, pos_y, corner_x, corner_y, radius, walkable,
                    input ready);
    modport sink (input valid, req_type, pos_x, pos_y, corner_x, corner_y, radius, walkable,
                  output ready);
endinterface

interface ogsp_rsp_if;
    logic valid;
    logic ready;
    logic accepted;
    logic cell_walkable;
    modport source (output valid, accepted, cell_walkable, input ready);
    modport sink (input valid, accepted, cell_walkable, output ready);
endinterface

interface ogsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [22:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/ogsp_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module ogsp_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ogsp_pkg::QUO_W-1:0]   dividend,
    input  logic [ogsp_pkg::CS_W-1:0]           divisor,
    output logic                                done,
    output logic signed [ogsp_pkg::QUO_W-1:0]   quotient
);

    localparam int MAG_W = ogsp_pkg::QUO_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [MAG_W-1:0]              mag_reg, mag_next;
    logic [ogsp_pkg::CS_W-1:0]     rem_reg, rem_next;
    logic [ogsp_pkg::CS_W-1:0]     dsr_reg, dsr_next;
    logic                          neg_reg, neg_next;
    logic signed [ogsp_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [ogsp_pkg::CS_W:0]       trial;
    logic [ogsp_pkg::QUO_W-1:0]    abs_dvd;
    logic [MAG_W-1:0]              mag_step;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        abs_dvd   = dividend[ogsp_pkg::QUO_W-1] ? -dividend : dividend;
        trial     = {rem_reg, mag_reg[MAG_W-1]};
        mag_step  = {mag_reg[MAG_W-2:0], 1'b0};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mag_next  = abs_dvd[MAG_W-1:0];
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[ogsp_pkg::QUO_W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = ogsp_pkg::CS_W'(trial - {1'b0, dsr_reg});
                mag_step[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[ogsp_pkg::CS_W-1:0];
            end
            mag_next = mag_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = neg_reg ? -$signed({1'b0, mag_step}) : $signed({1'b0, mag_step});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/occupancy_grid_shape_painter.sv
// Top level: occupancy grid painter with request sequencer and cell map.
// Keeps one walkable bit per cell of a 256 x 256 map and serves one request word at a
// time. After reset the map is swept to all-walkable, one cell per cycle; requests wait
// during that pass (configuration writes are taken). A set or read by cell index goes
// through ST_CHK (and ST_READ for a read) to ST_DONE. World coordinates are turned into
// cells by a shared one-bit-per-cycle divider: a point set takes two divisions, a
// rectangle or circle fill four, and then each rectangle cell is written in ST_CELL,
// while each circle cell of the clamped box steps through ST_CELL, ST_SQX and ST_CMP
// when its centre is outside the radius box, with ST_SQY added for the rest. The
// response sits in an output register, so the next request is taken while it waits.
module occupancy_grid_shape_painter
(
    input  logic       clk,
    input  logic       rst_n,
    ogsp_cfg_if.sink   cfg,
    ogsp_req_if.sink   req,
    ogsp_rsp_if.source rsp
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DIV_GO   = 4'd2;
    localparam logic [3:0] ST_DIV_WAIT = 4'd3;
    localparam logic [3:0] ST_CHK      = 4'd4;
    localparam logic [3:0] ST_READ     = 4'd5;
    localparam logic [3:0] ST_BOX      = 4'd6;
    localparam logic [3:0] ST_CELL     = 4'd7;
    localparam logic [3:0] ST_SQX      = 4'd8;
    localparam logic [3:0] ST_SQY      = 4'd9;
    localparam logic [3:0] ST_CMP      = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    localparam int CB = ogsp_pkg::COL_BITS;
    localparam int RB = ogsp_pkg::ROW_BITS;
    localparam int QW = ogsp_pkg::QUO_W;
    localparam int DW = 34;   // doubled centre offset

    // configuration
    logic [ogsp_pkg::DIM_W-1:0] gw_reg, gh_reg;
    logic [ogsp_pkg::CS_W-1:0]  cs_reg;
    logic [ogsp_pkg::DIM_W-1:0] wc, hc;
    logic [ogsp_pkg::CS_W-1:0]  cs_used;

    // sequencer
    logic [3:0]  state_reg, state_next;
    logic [ogsp_pkg::ADDR_BITS-1:0] clr_reg, clr_next;
    logic [1:0]  didx_reg, didx_next;
    logic        res_acc_reg, res_acc_next;
    logic        res_bit_reg, res_bit_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_acc_reg, out_acc_next;
    logic        out_bit_reg, out_bit_next;

    // request word
    logic [2:0]         typ_reg;
    logic signed [23:0] px_reg, py_reg, qx_reg, qy_reg;
    logic [22:0]        r_reg;
    logic               w_reg;
    logic [47:0]        lim2_reg;

    // indices and circle datapath
    logic signed [QW-1:0] q_reg [4];
    logic signed [QW-1:0] x_reg, x_next, y_reg, y_next;
    logic [CB-1:0] cx_reg, cx_next, x0_reg, x0_next, x1_reg, x1_next;
    logic [RB-1:0] cy_reg, cy_next, y0_reg, y0_next, y1_reg, y1_next;
    logic signed [DW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [49:0] sq_reg, sq_next;
    logic [50:0] sum_reg, sum_next;

    // divider
    logic                 div_start, div_done;
    logic signed [QW-1:0] div_dvd, div_quo;

    // cell map
    logic                                mem [2**ogsp_pkg::ADDR_BITS];
    logic                                mem_we, mem_wd, rd_reg;
    logic [ogsp_pkg::ADDR_BITS-1:0]      mem_addr;

    logic accept, last_cell, out_free;
    logic signed [DW-1:0] lim_s;
    logic [24:0] adx, ady;
    logic signed [DW-1:0] cen_x, cen_y;
    logic [CB:0] ctr_x;
    logic [RB:0] ctr_y;

    assign wc      = (gw_reg > ogsp_pkg::DIM_W'(ogsp_pkg::MAX_COLUMNS))
                     ? ogsp_pkg::DIM_W'(ogsp_pkg::MAX_COLUMNS) : gw_reg;
    assign hc      = (gh_reg > ogsp_pkg::DIM_W'(ogsp_pkg::MAX_ROWS))
                     ? ogsp_pkg::DIM_W'(ogsp_pkg::MAX_ROWS) : gh_reg;
    assign cs_used = (cs_reg == '0) ? ogsp_pkg::CS_W'(1) : cs_reg;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.cell_walkable = out_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= ogsp_pkg::DIM_W'(256);
            gh_reg <= ogsp_pkg::DIM_W'(256);
            cs_reg <= ogsp_pkg::CS_W'(256);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                ogsp_pkg::CFG_GRID_WIDTH:  gw_reg <= cfg.data[ogsp_pkg::DIM_W-1:0];
                ogsp_pkg::CFG_GRID_HEIGHT: gh_reg <= cfg.data[ogsp_pkg::DIM_W-1:0];
                ogsp_pkg::CFG_CELL_SIZE:   cs_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // divider operand: raw coordinates, or centre -/+ radius for circles
    always_comb
    begin
        logic signed [QW-1:0] rs;
        rs = $signed({3'b000, r_reg});
        case (didx_reg)
            2'd0: div_dvd = (typ_reg == ogsp_pkg::REQ_FILL_CIRC) ? QW'(px_reg) - rs : QW'(px_reg);
            2'd1: div_dvd = (typ_reg == ogsp_pkg::REQ_FILL_CIRC) ? QW'(py_reg) - rs : QW'(py_reg);
            2'd2: div_dvd = (typ_reg == ogsp_pkg::REQ_FILL_CIRC) ? QW'(px_reg) + rs : QW'(qx_reg);
            default: div_dvd = (typ_reg == ogsp_pkg::REQ_FILL_CIRC) ? QW'(py_reg) + rs
                                                                      : QW'(qy_reg);
        endcase
    end

    assign div_start = (state_reg == ST_DIV_GO);

    ogsp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (cs_used),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign last_cell = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    assign lim_s     = $signed({10'd0, r_reg, 1'b0});
    assign adx       = dx_reg[DW-1] ? 25'(-dx_reg) : dx_reg[24:0];
    assign ady       = dy_reg[DW-1] ? 25'(-dy_reg) : dy_reg[24:0];
    assign ctr_x     = {cx_reg, 1'b1};
    assign ctr_y     = {cy_reg, 1'b1};
    assign cen_x     = $signed({2'b00, 32'(ctr_x * cs_used)});
    assign cen_y     = $signed({2'b00, 32'(ctr_y * cs_used)});

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        didx_next      = didx_reg;
        res_acc_next   = res_acc_reg;
        res_bit_next   = res_bit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_acc_next   = out_acc_reg;
        out_bit_next   = out_bit_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        x0_next = x0_reg;
        x1_next = x1_reg;
        y0_next = y0_reg;
        y1_next = y1_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        sq_next = sq_reg;
        sum_next = sum_reg;
        mem_we   = 1'b0;
        mem_wd   = w_reg;
        mem_addr = {cy_reg, cx_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wd   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_acc_next = 1'b0;
                    res_bit_next = 1'b0;
                    didx_next    = 2'd0;
                    x_next       = QW'(req.pos_x);
                    y_next       = QW'(req.pos_y);
                    case (req.req_type)
                        ogsp_pkg::REQ_SET_CELL,
                        ogsp_pkg::REQ_READ_CELL: state_next = ST_CHK;
                        ogsp_pkg::REQ_SET_POINT,
                        ogsp_pkg::REQ_FILL_RECT,
                        ogsp_pkg::REQ_FILL_CIRC: state_next = ST_DIV_GO;
                        default:                 state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    didx_next = didx_reg + 1'b1;
                    if (typ_reg == ogsp_pkg::REQ_SET_POINT && didx_reg == 2'd1)
                    begin
                        x_next     = q_reg[0];
                        y_next     = div_quo;
                        state_next = ST_CHK;
                    end
                    else if (didx_reg == 2'd3)
                        state_next = ST_BOX;
                    else
                        state_next = ST_DIV_GO;
                end
            end
            ST_CHK:
            begin
                mem_addr = {y_reg[RB-1:0], x_reg[CB-1:0]};
                if (x_reg >= 0 && x_reg < $signed({17'd0, wc})
                    && y_reg >= 0 && y_reg < $signed({17'd0, hc}))
                begin
                    res_acc_next = 1'b1;
                    if (typ_reg == ogsp_pkg::REQ_READ_CELL)
                        state_next = ST_READ;
                    else
                    begin
                        mem_we     = 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                    state_next = ST_DONE;
            end
            ST_READ:
            begin
                res_bit_next = rd_reg;
                state_next   = ST_DONE;
            end
            ST_BOX:
            begin
                res_acc_next = 1'b1;
                x0_next = ogsp_pkg::clamp_idx(q_reg[0], wc);
                y0_next = ogsp_pkg::clamp_idx(q_reg[1], hc);
                x1_next = ogsp_pkg::clamp_idx(q_reg[2], wc);
                y1_next = ogsp_pkg::clamp_idx(div_quo, hc);
                cx_next = x0_next;
                cy_next = y0_next;
                if (wc == '0 || hc == '0 || x0_next > x1_next || y0_next > y1_next)
                    state_next = ST_DONE;
                else
                    state_next = ST_CELL;
            end
            ST_CELL:
            begin
                if (typ_reg == ogsp_pkg::REQ_FILL_CIRC)
                begin
                    dx_next    = cen_x - $signed({{9{px_reg[23]}}, px_reg, 1'b0});
                    dy_next    = cen_y - $signed({{9{py_reg[23]}}, py_reg, 1'b0});
                    state_next = ST_SQX;
                end
                else
                    mem_we = 1'b1;
            end
            ST_SQX:
            begin
                // outside the radius box: force the distance test to fail
                if (dx_reg > lim_s || dx_reg < -lim_s || dy_reg > lim_s || dy_reg < -lim_s)
                begin
                    sum_next   = '1;
                    state_next = ST_CMP;
                end
                else
                begin
                    sq_next    = adx * adx;
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                sum_next   = {1'b0, sq_reg} + 51'(ady * ady);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // circle cell write when the centre lies within the radius
                mem_we     = (sum_reg <= {3'b000, lim2_reg});
                state_next = ST_CELL;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = res_acc_reg;
                    out_bit_next   = res_bit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // box walk: plain rectangle steps from ST_CELL, circle from ST_CMP
        if ((state_reg == ST_CELL && typ_reg != ogsp_pkg::REQ_FILL_CIRC)
            || state_reg == ST_CMP)
        begin
            if (last_cell)
                state_next = ST_DONE;
            else if (cy_reg == y1_reg)
            begin
                cx_next = cx_reg + 1'b1;
                cy_next = y0_reg;
            end
            else
                cy_next = cy_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            typ_reg  <= req.req_type;
            px_reg   <= req.pos_x;
            py_reg   <= req.pos_y;
            qx_reg   <= req.corner_x;
            qy_reg   <= req.corner_y;
            r_reg    <= req.radius;
            w_reg    <= req.walkable;
            lim2_reg <= {req.radius, 1'b0} * {req.radius, 1'b0};
        end
        if (state_reg == ST_DIV_WAIT && div_done)
            q_reg[didx_reg] <= div_quo;
        didx_reg    <= didx_next;
        res_acc_reg <= res_acc_next;
        res_bit_reg <= res_bit_next;
        out_acc_reg <= out_acc_next;
        out_bit_reg <= out_bit_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        x0_reg <= x0_next;
        x1_reg <= x1_next;
        y0_reg <= y0_next;
        y1_reg <= y1_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        sq_reg <= sq_next;
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        rd_reg <= mem[mem_addr];
    end

endmodule

>>> verif/tb.sv
// Testbench for the occupancy grid shape painter: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] REQ_RESERVED_LO  = 3'd5;
    localparam logic [2:0] REQ_RESERVED_MID = 3'd6;
    localparam logic [2:0] REQ_RESERVED_HI  = 3'd7;
    localparam int         IDLE_LIMIT       = 400000;
    localparam int         REPORT_MAX       = 10;

    typedef struct {
        logic [2:0]         kind;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] qx;
        logic signed [23:0] qy;
        logic [22:0]        rad;
        logic               walk;
    } paint_req_t;

    typedef struct {
        logic accepted;
        logic cell_walkable;
    } paint_rsp_t;

    // One row of the directed table; fixed_rsp set means the answer is typed in.
    typedef struct {
        paint_req_t req;
        bit         fixed_rsp;
        paint_rsp_t rsp;
    } table_row_t;

    logic clk;
    logic rst_n;

    ogsp_cfg_if cfg_ch ();
    ogsp_req_if req_ch ();
    ogsp_rsp_if rsp_ch ();

    occupancy_grid_shape_painter u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow state of the painter.
    bit          shadow_map [ogsp_pkg::MAX_COLUMNS*ogsp_pkg::MAX_ROWS];
    logic [8:0]  shadow_width;
    logic [8:0]  shadow_height;
    logic [22:0] shadow_cell_size;

    paint_rsp_t  pending_rsp [$];
    table_row_t  directed_rows [$];

    int  fail_count;
    int  words_sent;
    int  words_checked;
    int  fills_sent;
    int  idle_cycles;
    bit  quiet;     // no gaps or stalls while set
    int  rsp_stall_left;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint cols_eff();
        return (shadow_width > ogsp_pkg::MAX_COLUMNS) ? ogsp_pkg::MAX_COLUMNS
                                                      : longint'(shadow_width);
    endfunction

    function automatic longint rows_eff();
        return (shadow_height > ogsp_pkg::MAX_ROWS) ? ogsp_pkg::MAX_ROWS
                                                    : longint'(shadow_height);
    endfunction

    function automatic longint cell_size_eff();
        return (shadow_cell_size == 0) ? 1 : longint'(shadow_cell_size);
    endfunction

    function automatic longint clamp_cell(longint v, longint hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Apply one request to the shadow map and return the response it must give.
    function automatic paint_rsp_t paint_and_answer(paint_req_t r);
        paint_rsp_t ans;
        longint cs, wc, hc, px, py, qx, qy, rad, x, y, x0, y0, x1, y1, dx, dy, lim;
        ans = '{1'b0, 1'b0};
        cs  = cell_size_eff();
        wc  = cols_eff();
        hc  = rows_eff();
        px  = r.px;
        py  = r.py;
        qx  = r.qx;
        qy  = r.qy;
        rad = longint'(r.rad);
        if (r.kind == ogsp_pkg::REQ_SET_CELL || r.kind == ogsp_pkg::REQ_SET_POINT
            || r.kind == ogsp_pkg::REQ_READ_CELL)
        begin
            x = px;
            y = py;
            if (r.kind == ogsp_pkg::REQ_SET_POINT)
            begin
                x = px / cs;    // truncates toward zero
                y = py / cs;
            end
            if (x >= 0 && x < wc && y >= 0 && y < hc)
            begin
                ans.accepted = 1'b1;
                if (r.kind == ogsp_pkg::REQ_READ_CELL)
                    ans.cell_walkable = shadow_map[y*ogsp_pkg::MAX_COLUMNS + x];
                else
                    shadow_map[y*ogsp_pkg::MAX_COLUMNS + x] = r.walk;
            end
        end
        else if (r.kind == ogsp_pkg::REQ_FILL_RECT || r.kind == ogsp_pkg::REQ_FILL_CIRC)
        begin
            ans.accepted = 1'b1;
            if (wc > 0 && hc > 0)
            begin
                if (r.kind == ogsp_pkg::REQ_FILL_RECT)
                begin
                    x0 = px / cs;  y0 = py / cs;
                    x1 = qx / cs;  y1 = qy / cs;
                end
                else
                begin
                    x0 = (px - rad) / cs;  y0 = (py - rad) / cs;
                    x1 = (px + rad) / cs;  y1 = (py + rad) / cs;
                end
                x0 = clamp_cell(x0, wc - 1);  x1 = clamp_cell(x1, wc - 1);
                y0 = clamp_cell(y0, hc - 1);  y1 = clamp_cell(y1, hc - 1);
                lim = 2 * rad;
                for (x = x0; x <= x1; x++)
                    for (y = y0; y <= y1; y++)
                    begin
                        if (r.kind == ogsp_pkg::REQ_FILL_CIRC)
                        begin
                            // cell centre vs. circle, in doubled units
                            dx = (2*x + 1) * cs - 2*px;
                            dy = (2*y + 1) * cs - 2*py;
                            if (dx > lim || dx < -lim || dy > lim || dy < -lim)
                                continue;
                            if (dx*dx + dy*dy > lim*lim)
                                continue;
                        end
                        shadow_map[y*ogsp_pkg::MAX_COLUMNS + x] = r.walk;
                    end
            end
        end
        return ans;
    endfunction

    // ---------------------------------------------------------------
    // Gap shaping: mostly back to back, some short gaps, a few long ones
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // Drivers (called at a rising edge, drive with NBAs)
    // ---------------------------------------------------------------
    task automatic send_word(input paint_req_t r, input bit fixed, input paint_rsp_t fixed_rsp);
        int gap;
        paint_rsp_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.pos_x    <= r.px;
        req_ch.pos_y    <= r.py;
        req_ch.corner_x <= r.qx;
        req_ch.corner_y <= r.qy;
        req_ch.radius   <= r.rad;
        req_ch.walkable <= r.walk;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        predicted = paint_and_answer(r);
        pending_rsp.push_back(fixed ? fixed_rsp : predicted);
        words_sent++;
        if (r.kind == ogsp_pkg::REQ_FILL_RECT || r.kind == ogsp_pkg::REQ_FILL_CIRC)
            fills_sent++;
    endtask

    // Let the block drain, then write one register.
    task automatic write_reg(input logic [1:0] idx, input logic [22:0] value);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        case (idx)
            ogsp_pkg::CFG_GRID_WIDTH:  shadow_width     = value[8:0];
            ogsp_pkg::CFG_GRID_HEIGHT: shadow_height    = value[8:0];
            ogsp_pkg::CFG_CELL_SIZE:   shadow_cell_size = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [8:0] w, input logic [8:0] h, input logic [22:0] cs);
        write_reg(ogsp_pkg::CFG_GRID_WIDTH, {14'd0, w});
        write_reg(ogsp_pkg::CFG_GRID_HEIGHT, {14'd0, h});
        write_reg(ogsp_pkg::CFG_CELL_SIZE, cs);
    endtask

    // ---------------------------------------------------------------
    // Random request maker
    // ---------------------------------------------------------------
    function automatic logic signed [23:0] fit24(longint v);
        if (v > 8388607)
            return 24'sd8388607;
        if (v < -8388608)
            return -24'sd8388608;
        return v[23:0];
    endfunction

    // A world coordinate within about one cell of the grid along an axis of n cells.
    function automatic longint near_world(longint n, longint cs);
        return longint'($urandom_range(0, 32'(n + 2) * 32'(cs))) - cs;
    endfunction

    function automatic paint_req_t make_random_req();
        paint_req_t r;
        longint cs, wc, hc, rad;
        bit noise;
        cs = cell_size_eff();
        wc = cols_eff();
        hc = rows_eff();
        if ($urandom_range(0, 99) < 3)
            r.kind = 3'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
        else
            r.kind = 3'($urandom_range(0, 4));
        r.px   = 24'($urandom);
        r.py   = 24'($urandom);
        r.qx   = 24'($urandom);
        r.qy   = 24'($urandom);
        r.rad  = 23'($urandom);
        r.walk = 1'($urandom);
        noise  = ($urandom_range(0, 9) == 0);
        case (r.kind)
            ogsp_pkg::REQ_SET_CELL, ogsp_pkg::REQ_READ_CELL:
                if (!noise)
                begin
                    r.px = 24'(longint'($urandom_range(0, 32'(wc) + 1)) - 1);
                    r.py = 24'(longint'($urandom_range(0, 32'(hc) + 1)) - 1);
                end
            ogsp_pkg::REQ_SET_POINT:
                if (!noise)
                begin
                    r.px = fit24(near_world(wc, cs));
                    r.py = fit24(near_world(hc, cs));
                end
            ogsp_pkg::REQ_FILL_RECT:
            begin
                // corner stays within one cell below to three cells above the first one so fills stay short
                if (!noise)
                begin
                    r.px = fit24(near_world(wc, cs));
                    r.py = fit24(near_world(hc, cs));
                end
                r.qx = fit24(longint'(r.px) + longint'($urandom_range(0, 32'(4*cs))) - cs);
                r.qy = fit24(longint'(r.py) + longint'($urandom_range(0, 32'(4*cs))) - cs);
            end
            ogsp_pkg::REQ_FILL_CIRC:
            begin
                if (!noise)
                begin
                    r.px = fit24(near_world(wc, cs));
                    r.py = fit24(near_world(hc, cs));
                end
                rad = longint'($urandom_range(0, 32'(3*cs)));
                r.rad = (rad > 8388607) ? 23'h7FFFFF : rad[22:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic random_phase(input int count);
        paint_rsp_t none;
        none = '{1'b0, 1'b0};
        for (int i = 0; i < count; i++)
        begin
            // a quiet stretch now and then
            if (i % 70 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_word(make_random_req(), 1'b0, none);
        end
        quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Directed table (default 256 x 256 grid, cell size 1.0)
    // ---------------------------------------------------------------
    function automatic void add_row(logic [2:0] kind, longint px, longint py, longint qx,
                                    longint qy, longint rad, bit walk, bit fixed,
                                    bit acc, bit cw);
        table_row_t row;
        row.req       = '{kind, px[23:0], py[23:0], qx[23:0], qy[23:0], rad[22:0], walk};
        row.fixed_rsp = fixed;
        row.rsp       = '{acc, cw};
        directed_rows.push_back(row);
    endfunction

    function automatic void build_table();
        // reads right after reset see the walkable default
        add_row(ogsp_pkg::REQ_READ_CELL, 0, 0, 0, 0, 0, 0, 1, 1, 1);
        add_row(ogsp_pkg::REQ_READ_CELL, 255, 255, 0, 0, 8388607, 1, 1, 1, 1);
        // just outside, negative and extreme indices, and the corner cell set and read back
        add_row(ogsp_pkg::REQ_READ_CELL, 256, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, -1, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, -8388608, 8388607, 0, 0, 0, 0, 1, 0, 0);
        add_row(ogsp_pkg::REQ_SET_CELL, 255, 255, 0, 0, 0, 0, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 255, 255, 0, 0, 0, 1, 1, 1, 0);
        add_row(ogsp_pkg::REQ_SET_CELL, 8388607, 0, 0, 0, 0, 0, 1, 0, 0);
        // half a cell below zero still lands in cell 0
        add_row(ogsp_pkg::REQ_SET_POINT, -128, -128, 0, 0, 0, 0, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 0, 0, 0, 0, 0, 0, 1, 1, 0);
        add_row(ogsp_pkg::REQ_SET_POINT, 8388607, 0, 0, 0, 0, 1, 1, 0, 0);
        // whole-range rectangle clamps to the full grid
        add_row(ogsp_pkg::REQ_FILL_RECT, -8388608, -8388608, 8388607, 8388607, 0, 0, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 100, 100, 0, 0, 0, 0, 1, 1, 0);
        // inverted corners: nothing written
        add_row(ogsp_pkg::REQ_FILL_RECT, 2560, 0, 0, 2560, 0, 1, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 5, 5, 0, 0, 0, 0, 0, 0, 0);
        add_row(ogsp_pkg::REQ_FILL_RECT, 0, 0, 768, 768, 0, 1, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 3, 3, 0, 0, 0, 0, 1, 1, 1);
        add_row(ogsp_pkg::REQ_FILL_CIRC, 1280, 1280, 0, 0, 512, 1, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 4, 5, 0, 0, 0, 0, 0, 0, 0);
        // zero radius on a cell centre marks that one cell
        add_row(ogsp_pkg::REQ_FILL_CIRC, 2432, 2432, 0, 0, 0, 1, 1, 1, 0);
        add_row(ogsp_pkg::REQ_READ_CELL, 9, 9, 0, 0, 0, 0, 1, 1, 1);
        add_row(REQ_RESERVED_LO, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(REQ_RESERVED_MID, 1, 1, 0, 0, 0, 1, 1, 0, 0);
        add_row(REQ_RESERVED_HI, 2, 2, 0, 0, 0, 0, 1, 0, 0);
    endfunction

    // ---------------------------------------------------------------
    // Response side: random backpressure and the scoreboard
    // ---------------------------------------------------------------
    initial begin
        paint_rsp_t want;
        rsp_stall_left = 0;
        rsp_ch.ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                words_checked++;
                if (pending_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%t: response word with nothing outstanding", $realtime);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_ch.accepted !== want.accepted
                        || rsp_ch.cell_walkable !== want.cell_walkable)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%t: accepted exp %0b got %0b, walkable exp %0b got %0b",
                                     $realtime, want.accepted, rsp_ch.accepted,
                                     want.cell_walkable, rsp_ch.cell_walkable);
                    end
                end
            end
            if (rsp_stall_left > 0)
            begin
                rsp_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready   <= 1'b1;
                rsp_stall_left = pick_gap();
            end
        end
    end

    // Watchdog: cycles with no word moving on any channel.
    initial begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles, %0d responses outstanding",
                         idle_cycles, pending_rsp.size());
                $display("occupancy_grid_shape_painter verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = ogsp_pkg::REQ_SET_CELL;
        req_ch.pos_x    = '0;
        req_ch.pos_y    = '0;
        req_ch.corner_x = '0;
        req_ch.corner_y = '0;
        req_ch.radius   = '0;
        req_ch.walkable = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ogsp_pkg::CFG_GRID_WIDTH;
        cfg_ch.data     = '0;
        fail_count      = 0;
        words_sent      = 0;
        words_checked   = 0;
        fills_sent      = 0;
        quiet           = 1'b0;
        shadow_width     = 9'd256;
        shadow_height    = 9'd256;
        shadow_cell_size = 23'd256;
        foreach (shadow_map[i])
            shadow_map[i] = 1'b1;
        build_table();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].req, directed_rows[i].fixed_rsp, directed_rows[i].rsp);

        // small odd grid: reads often hit written cells
        set_grid(9'd16, 9'd12, 23'd256);
        random_phase(210);
        // oversized dimensions clamp to the map size
        set_grid(9'd511, 9'd300, 23'd1024);
        random_phase(210);
        // zero width, zero cell size
        set_grid(9'd0, 9'd5, 23'd0);
        random_phase(210);
        // single cell, largest cell size
        set_grid(9'd1, 9'd1, 23'h7FFFFF);
        random_phase(210);
        set_grid(9'd7, 9'd9, 23'd100);
        random_phase(210);

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d request words (%0d fills) over six grid settings",
                 words_sent, fills_sent);
        $display("checked %0d responses under random gaps and backpressure", words_checked);
        if (fail_count == 0)
            $display("occupancy_grid_shape_painter verification clean");
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("occupancy_grid_shape_painter verification failed");
        end
        $finish;
    end

endmodule
